// ----- hdl/hwl_pkg.sv -----
package hwl_pkg;

    localparam int VoltW = 11;
    localparam int VelW  = 16;
    localparam int SegW  = 2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_ZERO_WIND  = 3'd0;
    localparam logic [2:0] REG_SEG1       = 3'd1;
    localparam logic [2:0] REG_SEG2       = 3'd2;
    localparam logic [2:0] REG_SEG3       = 3'd3;
    localparam logic [2:0] REG_SPLIT_LOW  = 3'd4;
    localparam logic [2:0] REG_SPLIT_HIGH = 3'd5;

    // segment codes
    localparam logic [1:0] SEG_NONE = 2'd0;
    localparam logic [1:0] SEG_ONE  = 2'd1;
    localparam logic [1:0] SEG_TWO  = 2'd2;
    localparam logic [1:0] SEG_THREE = 2'd3;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [21:0] LN1E6_Q16 = 22'd905413;

    typedef struct packed {
        logic [VoltW-1:0] zero_wind_mv;
        logic [31:0]      seg1_coeffs;
        logic [31:0]      seg2_coeffs;
        logic [31:0]      seg3_coeffs;
        logic [15:0]      split_low;
        logic [15:0]      split_high;
    } cfg_t;

    typedef struct packed {
        logic       load_in;
        logic       sq;
        logic       norm;
        logic       log_step;
        logic       ln;
        logic       smul;
        logic       schk;
        logic       exp_step;
        logic       efin;
        logic       adv;
        logic       out_load;
        logic [3:0] idx;
    } cmd_t;

    typedef struct packed {
        logic d_pos;
        logic a_hi;
        logic a_lo;
        logic adv;
    } sts_t;

    // c_idx = 2^(2^-idx) in q2.30, built by repeated floor square roots
    function automatic logic [31:0] exp_coef(input int idx);
        logic [63:0] c;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd1 << 31;
        for (int i = 0; i < 16; i++) begin
            if (i < idx) begin
                x = c << 30;
                r = 64'd0;
                b = 64'd1 << 62;
                for (int j = 0; j < 32; j++) begin
                    if (x >= r + b) begin
                        x = x - (r + b);
                        r = (r >> 1) + b;
                    end
                    else begin
                        r = r >> 1;
                    end
                    b = b >> 2;
                end
                c = r;
            end
        end
        return c[31:0];
    endfunction

endpackage

// ----- hdl/hwl_cfg.sv -----
module hwl_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output hwl_pkg::cfg_t cfg
);
    import hwl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_wind_mv <= '0;
            cfg_reg.seg1_coeffs  <= '0;
            cfg_reg.seg2_coeffs  <= '0;
            cfg_reg.seg3_coeffs  <= '0;
            cfg_reg.split_low    <= 16'hFFFF;
            cfg_reg.split_high   <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZERO_WIND:  cfg_reg.zero_wind_mv <= cfg_data[VoltW-1:0];
                REG_SEG1:       cfg_reg.seg1_coeffs  <= cfg_data;
                REG_SEG2:       cfg_reg.seg2_coeffs  <= cfg_data;
                REG_SEG3:       cfg_reg.seg3_coeffs  <= cfg_data;
                REG_SPLIT_LOW:  cfg_reg.split_low    <= cfg_data[15:0];
                REG_SPLIT_HIGH: cfg_reg.split_high   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/hwl_ctrl.sv -----
module hwl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  hwl_pkg::sts_t sts,
    output hwl_pkg::cmd_t cmd
);
    import hwl_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_SQ     = 11'b00000000010,
        ST_NORM   = 11'b00000000100,
        ST_LOG    = 11'b00000001000,
        ST_LN     = 11'b00000010000,
        ST_SMUL   = 11'b00000100000,
        ST_SCHK   = 11'b00001000000,
        ST_EXP    = 11'b00010000000,
        ST_EFIN   = 11'b00100000000,
        ST_DECIDE = 11'b01000000000,
        ST_DONE   = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;
    logic       free;

    assign free = !ov_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.norm   = 1'b1;
                cnt_next   = '0;
                state_next = sts.d_pos ? ST_LOG : ST_DONE;
            end
            ST_LOG:
            begin
                cmd.log_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_LN;
            end
            ST_LN:
            begin
                cmd.ln     = 1'b1;
                state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                cmd.smul   = 1'b1;
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                cmd.schk   = 1'b1;
                cnt_next   = '0;
                state_next = (sts.a_hi || sts.a_lo) ? ST_DECIDE : ST_EXP;
            end
            ST_EXP:
            begin
                cmd.exp_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_EFIN;
            end
            ST_EFIN:
            begin
                cmd.efin   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.adv)
                begin
                    cmd.adv    = 1'b1;
                    state_next = ST_SMUL;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg && !m_tready;
        if (cmd.out_load)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;

endmodule

// ----- hdl/hwl_dp.sv -----
module hwl_dp (
    input  logic                      clk,
    input  hwl_pkg::cfg_t             cfg,
    input  hwl_pkg::cmd_t             cmd,
    output hwl_pkg::sts_t             sts,
    input  logic [hwl_pkg::VoltW-1:0] bridge_mv,
    output logic [hwl_pkg::VelW-1:0]  velocity_q8_8,
    output logic [hwl_pkg::SegW-1:0]  segment_used,
    output logic                      saturated
);
    import hwl_pkg::*;

    logic [VoltW-1:0]  v_reg;
    logic [22:0]       d_reg;
    logic [30:0]       q_reg;
    logic [20:0]       lg_reg;
    logic signed [21:0] l_reg;
    logic signed [27:0] a_reg;
    logic [21:0]       u_reg;
    logic [31:0]       p_reg;
    logic [VelW-1:0]   vel_reg;
    logic [SegW-1:0]   seg_reg;
    logic              sat_reg;
    logic [VelW-1:0]   ovel_reg;
    logic [SegW-1:0]   oseg_reg;
    logic              osat_reg;

    logic [31:0] ctab [16];

    genvar gi;
    generate
        for (gi = 0; gi < 16; gi++)
        begin : g_ctab
            assign ctab[gi] = exp_coef(gi + 1);
        end
    endgenerate

    // no flow when d is zero or negative
    logic d_pos;
    assign d_pos = !d_reg[22] && (d_reg[21:0] != '0);

    // leading one of d
    logic [4:0] k;
    always_comb
    begin
        k = '0;
        for (int i = 0; i < 22; i++)
            if (d_reg[i])
                k = 5'(i);
    end

    logic [4:0]  nsh;
    logic [30:0] q_init;
    assign nsh    = 5'd30 - k;
    assign q_init = {9'd0, d_reg[21:0]} << nsh;

    // one squaring step of the log
    logic [61:0] qsq;
    logic [31:0] qs;
    assign qsq = {31'd0, q_reg} * {31'd0, q_reg};
    assign qs  = qsq[61:30];

    logic [52:0] lnp;
    logic [20:0] ln_q16;
    assign lnp    = {32'd0, lg_reg} * {21'd0, LN2_Q32};
    assign ln_q16 = 21'((lnp + 53'd2147483648) >> 32);

    // segment argument
    logic [31:0] coef;
    always_comb
    begin
        case (seg_reg)
            SEG_TWO:   coef = cfg.seg2_coeffs;
            SEG_THREE: coef = cfg.seg3_coeffs;
            default:   coef = cfg.seg1_coeffs;
        endcase
    end

    logic signed [39:0] s_sum;
    logic signed [39:0] s_rnd;
    assign s_sum = 40'(($signed(coef[31:16]) * l_reg))
                 + ($signed({{6{coef[15]}}, coef[15:0], 18'd0}));
    assign s_rnd = s_sum + 40'sd2048;

    logic a_hi, a_lo;
    assign a_hi = (a_reg > 28'sd393216);
    assign a_lo = (a_reg < -28'sd786432);

    logic signed [52:0] t;
    logic signed [53:0] tsum;
    assign t    = $signed(a_reg[20:0]) * $signed({1'b0, LOG2E_Q30});
    assign tsum = 54'(t) + 54'sd2251799813685248 + 54'sd536870912;

    logic [63:0] pc;
    logic [31:0] p_step;
    assign pc     = {32'd0, p_reg} * {32'd0, ctab[cmd.idx]};
    assign p_step = 32'((pc + 64'd536870912) >> 30);

    logic [5:0]  n;
    logic [5:0]  sh;
    logic [63:0] vround;
    assign n      = u_reg[21:16];
    assign sh     = 6'd54 - n;
    assign vround = ({32'd0, p_reg} + (64'd1 << (sh - 6'd1))) >> sh;

    logic adv;
    assign adv = ((seg_reg == SEG_ONE) && (vel_reg >= cfg.split_low))
              || ((seg_reg == SEG_TWO) && (vel_reg >= cfg.split_high));

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            v_reg <= bridge_mv;
        if (cmd.sq)
            d_reg <= {1'b0, 22'(v_reg * v_reg)}
                   - {1'b0, 22'(cfg.zero_wind_mv * cfg.zero_wind_mv)};
        if (cmd.norm)
        begin
            q_reg   <= q_init;
            lg_reg  <= {k, 16'd0};
            vel_reg <= '0;
            sat_reg <= 1'b0;
            seg_reg <= d_pos ? SEG_ONE : SEG_NONE;
        end
        if (cmd.log_step)
        begin
            if (qs[31])
            begin
                q_reg <= qs[31:1];
                lg_reg[4'd15 - cmd.idx] <= 1'b1;
            end
            else
                q_reg <= qs[30:0];
        end
        if (cmd.ln)
            l_reg <= $signed({1'b0, ln_q16}) - $signed(LN1E6_Q16);
        if (cmd.smul)
            a_reg <= 28'(s_rnd >>> 12);
        if (cmd.schk)
        begin
            if (a_hi)
            begin
                vel_reg <= '1;
                sat_reg <= 1'b1;
            end
            else if (a_lo)
            begin
                vel_reg <= '0;
                sat_reg <= 1'b0;
            end
            u_reg <= tsum[51:30];
            p_reg <= 32'd1 << 30;
        end
        if (cmd.exp_step && u_reg[4'd15 - cmd.idx])
            p_reg <= p_step;
        if (cmd.efin)
        begin
            if (n >= 6'd54 || vround > 64'd65535)
            begin
                vel_reg <= '1;
                sat_reg <= 1'b1;
            end
            else
            begin
                vel_reg <= vround[VelW-1:0];
                sat_reg <= 1'b0;
            end
        end
        if (cmd.adv)
            seg_reg <= seg_reg + 2'd1;
        if (cmd.out_load)
        begin
            ovel_reg <= vel_reg;
            oseg_reg <= seg_reg;
            osat_reg <= sat_reg;
        end
    end

    assign sts.d_pos = d_pos;
    assign sts.a_hi  = a_hi;
    assign sts.a_lo  = a_lo;
    assign sts.adv   = adv;

    assign velocity_q8_8 = ovel_reg;
    assign segment_used  = oseg_reg;
    assign saturated     = osat_reg;

endmodule

// ----- hdl/hot_wire_velocity_linearizer_top.sv -----
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata[10:0] bridge_mv
// m_*       out  m_tvalid/m_tready  m_tdata velocity, segment, saturated flag
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// one beat in at a time, held longest when all three segments run; the serial log
// (16 squarings) and the serial exp (16 coefficient multiply steps per segment)
// set how long a beat takes, and a no-flow beat skips both
// the result sits in an output register, so a new beat is taken while it waits
// rst_n clears control and restores register defaults asynchronously
module hot_wire_velocity_linearizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] bridge_mv, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] velocity_q8_8, [17:16] segment_used, [18] saturated
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import hwl_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    logic [VelW-1:0] velocity_q8_8;
    logic [SegW-1:0] segment_used;
    logic            saturated;

    // configuration registers
    hwl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: for positive d a log, then per segment a range check and, unless it is out of range, one exp pass
    hwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and result register
    hwl_dp u_dp (
        .clk           (clk),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .bridge_mv     (s_tdata[VoltW-1:0]),
        .velocity_q8_8 (velocity_q8_8),
        .segment_used  (segment_used),
        .saturated     (saturated)
    );

    assign m_tdata = {5'd0, saturated, segment_used, velocity_q8_8};

endmodule
